>>> design/hmac_md5_digest_engine_assert.svh
`ifndef HMAC_MD5_DIGEST_ENGINE_ASSERT_SVH
`define HMAC_MD5_DIGEST_ENGINE_ASSERT_SVH

// property checked only while out of reset
`define HMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked during reset as well
`define HMD_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/hmd_pkg.sv
package hmd_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IPAD,
        ST_MSG,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_FIN,
        ST_OPAD,
        ST_INNER,
        ST_RD,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef logic [3:0][31:0] chain_t;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5C;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'h3F;

    localparam chain_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] S_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        return K_TAB[i];
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        return S_TAB[{i[5:4], i[1:0]}];
    endfunction

    // message word index used by round i
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] lo;
        logic [3:0] g;
        lo = i[3:0];
        unique case (i[5:4])
            2'd0: g = lo;
            2'd1: g = (lo << 2) + lo + 4'd1;
            2'd2: g = (lo << 1) + lo + 4'd5;
            2'd3: g = (lo << 3) - lo;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [1:0] q, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (q)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

>>> design/hmac_md5_digest_engine.sv
// HMAC-MD5 / MD5 digest engine.
// Input stream: one message byte per request. s_tdata carries the byte,
// s_tuser[0] says a byte is present (0 on an empty-message marker),
// s_tuser[1] selects HMAC-MD5 on the first request of a message, s_tlast
// closes the message. The result stream gives one 128-bit digest per message
// on m_tdata (bytes 0..15, byte 0 in the low bits).
// Key port: cfg_index picks one of eight 64-bit key words, written whenever
// cfg_valid is high; it is always ready.
// Flow: bytes are taken one at a time; a new request is accepted only once the
// previous byte is pushed, and every 64th byte of a hash first runs the
// compression (64 rounds at one round per cycle from the block memory, plus a
// prefetch and a chaining add). Padding pushes the 0x80 mark, zero bytes and the
// bit length. Keyed mode pushes 64 inner key pad bytes at message start, and at
// the end runs the outer hash (64 key bytes, 16 digest bytes, padding, two
// compressions).
// Reset restores the MD5 initial chaining words, clears the bit count,
// the key and any open message. A stalled result waits in the output
// register while the next message is already taken in; a second digest
// waits until the first one is taken.
module hmac_md5_digest_engine (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic [1:0]   s_tuser,   // byte_present, keyed_mode
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // digest_low, digest_high
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    hmd_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [5:0]   cnt_reg, cnt_next, rnd_reg, rnd_next;
    logic [63:0]  len_reg, len_next, len_snap_reg, len_snap_next;
    hmd_pkg::chain_t chain_reg, chain_next, inner_reg, inner_next;
    logic [7:0][63:0] key_reg;
    logic [31:0]  acc_reg, acc_next;
    logic [7:0]   byte_reg, byte_next;
    logic         present_reg, present_next, last_reg, last_next;
    logic         keyed_reg, keyed_next, open_reg, open_next, outer_reg, outer_next;
    logic [31:0]  a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic         m_valid_reg, m_valid_next;
    logic [127:0] m_data_reg, m_data_next;

    // block buffer memory
    logic [31:0]  buf_mem [16];
    logic [31:0]  rd_data_reg;
    logic [3:0]   rd_addr, wr_addr;
    logic [31:0]  wr_data;
    logic         wr_en;

    logic         push_en;
    logic [7:0]   push_data;
    logic [5:0]   push_pos;
    logic [31:0]  sum;
    logic [63:0]  rot;

    assign s_tready  = (state_reg == hmd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign push_pos  = len_reg[8:3];

    // one md5 round
    assign sum = a_reg + hmd_pkg::md5_f(rnd_reg[5:4], b_reg, c_reg, d_reg)
               + hmd_pkg::md5_k(rnd_reg) + rd_data_reg;
    assign rot = {sum, sum} << hmd_pkg::md5_s(rnd_reg);

    // memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid) begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hmd_pkg::ST_IDLE;
            ret_reg     <= hmd_pkg::ST_IDLE;
            chain_reg   <= hmd_pkg::CHAIN_INIT;
            len_reg     <= '0;
            keyed_reg   <= 1'b0;
            open_reg    <= 1'b0;
            outer_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            rnd_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            chain_reg   <= chain_next;
            len_reg     <= len_next;
            keyed_reg   <= keyed_next;
            open_reg    <= open_next;
            outer_reg   <= outer_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            rnd_reg     <= rnd_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        len_snap_reg <= len_snap_next;
        inner_reg    <= inner_next;
        acc_reg      <= acc_next;
        byte_reg     <= byte_next;
        present_reg  <= present_next;
        last_reg     <= last_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        m_data_reg   <= m_data_next;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        cnt_next      = cnt_reg;
        rnd_next      = rnd_reg;
        len_next      = len_reg;
        len_snap_next = len_snap_reg;
        chain_next    = chain_reg;
        inner_next    = inner_reg;
        acc_next      = acc_reg;
        byte_next     = byte_reg;
        present_next  = present_reg;
        last_next     = last_reg;
        keyed_next    = keyed_reg;
        open_next     = open_reg;
        outer_next    = outer_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        push_en       = 1'b0;
        push_data     = '0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = push_pos[5:2];
        wr_data       = {push_data, acc_reg[23:0]};

        unique case (state_reg)
            hmd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    byte_next    = s_tdata;
                    present_next = s_tuser[0];
                    last_next    = s_tlast;
                    state_next   = hmd_pkg::ST_MSG;
                    if (!open_reg) begin
                        keyed_next = s_tuser[1];
                        open_next  = 1'b1;
                        chain_next = hmd_pkg::CHAIN_INIT;
                        len_next   = '0;
                        cnt_next   = '0;
                        if (s_tuser[1]) begin
                            state_next = hmd_pkg::ST_IPAD;
                        end
                    end
                end
            end
            hmd_pkg::ST_IPAD, hmd_pkg::ST_OPAD: begin
                push_en   = 1'b1;
                push_data = key_reg[cnt_reg[5:3]][{cnt_reg[2:0], 3'b000} +: 8]
                          ^ ((state_reg == hmd_pkg::ST_IPAD) ? hmd_pkg::IPAD_BYTE
                                                               : hmd_pkg::OPAD_BYTE);
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == hmd_pkg::LAST_POS) begin
                    state_next = (state_reg == hmd_pkg::ST_IPAD) ? hmd_pkg::ST_MSG
                                                                 : hmd_pkg::ST_INNER;
                end
            end
            hmd_pkg::ST_MSG: begin
                push_en    = present_reg;
                push_data  = byte_reg;
                state_next = last_reg ? hmd_pkg::ST_PAD80 : hmd_pkg::ST_IDLE;
            end
            hmd_pkg::ST_INNER: begin
                push_en   = 1'b1;
                push_data = inner_reg[cnt_reg[3:2]][{cnt_reg[1:0], 3'b000} +: 8];
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg[3:0] == 4'hF) begin
                    state_next = hmd_pkg::ST_PAD80;
                end
            end
            hmd_pkg::ST_PAD80: begin
                len_snap_next = len_reg;
                push_en       = 1'b1;
                push_data     = hmd_pkg::PAD_MARK;
                state_next    = hmd_pkg::ST_PADZ;
            end
            hmd_pkg::ST_PADZ: begin
                if (push_pos == hmd_pkg::LEN_POS) begin
                    cnt_next   = '0;
                    state_next = hmd_pkg::ST_LEN;
                end else begin
                    push_en = 1'b1;
                end
            end
            hmd_pkg::ST_LEN: begin
                push_en   = 1'b1;
                push_data = len_snap_reg[{cnt_reg[2:0], 3'b000} +: 8];
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7) begin
                    state_next = hmd_pkg::ST_FIN;
                end
            end
            hmd_pkg::ST_FIN: begin
                if (keyed_reg && !outer_reg) begin
                    inner_next = chain_reg;
                    chain_next = hmd_pkg::CHAIN_INIT;
                    len_next   = '0;
                    outer_next = 1'b1;
                    cnt_next   = '0;
                    state_next = hmd_pkg::ST_OPAD;
                end else begin
                    state_next = hmd_pkg::ST_DONE;
                end
            end
            hmd_pkg::ST_RD: begin
                rd_addr    = '0;
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                rnd_next   = '0;
                state_next = hmd_pkg::ST_ROUND;
            end
            hmd_pkg::ST_ROUND: begin
                // prefetch the word for the following round
                rd_addr  = hmd_pkg::md5_g(rnd_reg + 6'd1);
                a_next   = d_reg;
                b_next   = b_reg + rot[63:32];
                c_next   = b_reg;
                d_next   = c_reg;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == hmd_pkg::LAST_POS) begin
                    state_next = hmd_pkg::ST_ADD;
                end
            end
            hmd_pkg::ST_ADD: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                state_next    = ret_reg;
            end
            hmd_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = chain_reg;
                    m_valid_next = 1'b1;
                    open_next    = 1'b0;
                    outer_next   = 1'b0;
                    state_next   = hmd_pkg::ST_IDLE;
                end
            end
            default: state_next = hmd_pkg::ST_IDLE;
        endcase

        // byte push into the word assembler, full words go to memory
        if (push_en) begin
            acc_next[{push_pos[1:0], 3'b000} +: 8] = push_data;
            len_next = len_reg + 64'd8;
            if (push_pos[1:0] == 2'd3) begin
                wr_en   = 1'b1;
                wr_data = {push_data, acc_reg[23:0]};
            end
            // block full: compress, then resume where the push left off
            if (push_pos == hmd_pkg::LAST_POS) begin
                ret_next   = state_next;
                state_next = hmd_pkg::ST_RD;
            end
        end
    end

endmodule

>>> design/hmd_checker.sv
`include "hmac_md5_digest_engine_assert.svh"

module hmd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // a held digest keeps its value
    `HMD_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "digest changed while stalled")

    // one request at a time: busy right after taking one
    `HMD_ASSERT(a_busy_after, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    // a digest never shows up right after a request that is not last
    `HMD_ASSERT(a_no_early, s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid), "early digest")

    // reset empties the output
    `HMD_ASSERT_ANY(a_reset_out, !aresetn |=> !m_tvalid, "digest valid after reset")

endmodule

bind hmac_md5_digest_engine hmd_checker u_hmd_checker (.*);
